/* src/lpg_pkg.sv */
// Package for the lexicographic permutation generator: function codes, register
// index, sequencer step names, control word type and the microcode table.
// Depends on nothing; used by lexicographic_permutation_generator.
package lpg_pkg;

   localparam logic [1:0] F_LOAD    = 2'd0;
   localparam logic [1:0] F_EMIT    = 2'd1;
   localparam logic [1:0] F_ADVANCE = 2'd2;

   localparam logic CSR_LENGTH_IDX = 1'b0;
   localparam logic [3:0] LENGTH_RESET = 4'd8;

   typedef enum logic [3:0] {
      U_IDLE,
      U_EMIT_SET,
      U_PIV_SET,
      U_PIV_SCAN,
      U_PIV_END,
      U_SUCC,
      U_SWAP_A,
      U_SWAP_B,
      U_SETTLE,
      U_REV,
      U_WRAP,
      U_REV_B,
      U_EMIT
   } step_type;

   typedef enum logic [2:0] {P_HOLD, P_ZERO, P_INC, P_PIV, P_PIV1} p_op_type;
   typedef enum logic [2:0] {Q_HOLD, Q_ONE, Q_INC, Q_DEC, Q_LAST} q_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_LOAD, WR_P_RDB, WR_Q_T} wr_sel_type;
   typedef enum logic [1:0] {WRAP_HOLD, WRAP_CLR, WRAP_SET} wrap_op_type;
   typedef enum logic [1:0] {G_ALWAYS, G_TRUE, G_FALSE, G_FREE} gate_type;
   typedef enum logic [2:0] {
      C_ALWAYS, C_DISPATCH, C_SCAN, C_FOUND, C_SUCC, C_REV_DONE, C_EMIT_DONE
   } cond_type;

   typedef struct packed {
      logic        take;
      p_op_type    p_op;
      q_op_type    q_op;
      wr_sel_type  wr_sel;
      logic        t_load;
      logic        piv_chk;
      logic        found_clr;
      wrap_op_type wrap_op;
      logic        emit;
      gate_type    gate;
      cond_type    cond;
      step_type    tgt_t;
      step_type    tgt_f;
   } ctl_word_type;

   localparam ctl_word_type CTL_NOP = '{
      take: 1'b0, p_op: P_HOLD, q_op: Q_HOLD, wr_sel: WR_NONE, t_load: 1'b0,
      piv_chk: 1'b0, found_clr: 1'b0, wrap_op: WRAP_HOLD, emit: 1'b0,
      gate: G_ALWAYS, cond: C_ALWAYS, tgt_t: U_IDLE, tgt_f: U_IDLE
   };

   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type w;
      w = CTL_NOP;
      case (s)
         U_IDLE: begin
            w.take    = 1'b1;
            w.wr_sel  = WR_LOAD;
            w.wrap_op = WRAP_CLR;
            w.cond    = C_DISPATCH;
         end
         U_EMIT_SET: begin
            w.p_op  = P_ZERO;
            w.tgt_t = U_EMIT;
         end
         U_PIV_SET: begin
            w.p_op      = P_ZERO;
            w.q_op      = Q_ONE;
            w.found_clr = 1'b1;
            w.tgt_t     = U_PIV_SCAN;
         end
         U_PIV_SCAN: begin
            w.p_op    = P_INC;
            w.q_op    = Q_INC;
            w.piv_chk = 1'b1;
            w.cond    = C_SCAN;
            w.tgt_t   = U_PIV_SCAN;
            w.tgt_f   = U_PIV_END;
         end
         U_PIV_END: begin
            w.p_op  = P_PIV;
            w.q_op  = Q_LAST;
            w.cond  = C_FOUND;
            w.tgt_t = U_SUCC;
            w.tgt_f = U_WRAP;
         end
         U_SUCC: begin
            w.q_op  = Q_DEC;
            w.gate  = G_TRUE;
            w.cond  = C_SUCC;
            w.tgt_t = U_SUCC;
            w.tgt_f = U_SWAP_A;
         end
         U_SWAP_A: begin
            w.wr_sel = WR_P_RDB;
            w.t_load = 1'b1;
            w.tgt_t  = U_SWAP_B;
         end
         U_SWAP_B: begin
            w.wr_sel = WR_Q_T;
            w.p_op   = P_PIV1;
            w.q_op   = Q_LAST;
            w.tgt_t  = U_SETTLE;
         end
         U_SETTLE: begin
            w.tgt_t = U_REV;
         end
         U_REV: begin
            w.wr_sel = WR_P_RDB;
            w.t_load = 1'b1;
            w.gate   = G_FALSE;
            w.cond   = C_REV_DONE;
            w.tgt_t  = U_EMIT_SET;
            w.tgt_f  = U_REV_B;
         end
         U_WRAP: begin
            w.p_op    = P_ZERO;
            w.q_op    = Q_LAST;
            w.wrap_op = WRAP_SET;
            w.tgt_t   = U_SETTLE;
         end
         U_REV_B: begin
            w.wr_sel = WR_Q_T;
            w.p_op   = P_INC;
            w.q_op   = Q_DEC;
            w.tgt_t  = U_REV;
         end
         U_EMIT: begin
            w.p_op  = P_INC;
            w.emit  = 1'b1;
            w.gate  = G_FREE;
            w.cond  = C_EMIT_DONE;
            w.tgt_t = U_IDLE;
            w.tgt_f = U_EMIT;
         end
         default: begin
            w = CTL_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

/* src/lpg_ram.sv */
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module lpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/lexicographic_permutation_generator.sv */
// Lexicographic permutation generator. Holds up to MAX_LEN elements in a small
// two-read-port RAM and steps them through every permutation in ascending
// lexicographic order under a microcoded sequencer that handles one element per
// step. A load is written straight from the idle step. An emit returns one
// word per position, position 0 first, last set on the final one. An advance
// scans for the pivot, walks down to the successor, swaps the two and reverses
// the suffix, or, when no pivot is found, reverses the whole arrangement and
// marks it wrapped; then it emits. The step rate is set by the RAM, which gives
// two reads and one write a cycle. A new word is taken only while the sequencer
// is idle; the output register lets the next word in while the last result
// still waits. length reads as 1 when 0 and saturates at MAX_LEN. Depends on
// lpg_pkg and lpg_ram.
module lexicographic_permutation_generator #(
   parameter int MAX_LEN    = 8,
   parameter int ELEM_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_index,
   input  logic [7:0]  req_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_position,
   output logic [7:0]  rsp_element,
   output logic        rsp_last,
   output logic        rsp_wrapped,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int EW = ELEM_WIDTH;
   localparam logic [4:0] MAX5 = 5'(MAX_LEN);

   lpg_pkg::step_type     upc_ff, upc_in;
   lpg_pkg::ctl_word_type ctl;

   logic [3:0]    length_ff, length_in;
   logic [CW-1:0] p_ff, p_in, q_ff, q_in, piv_ff, piv_in;
   logic          found_ff, found_in, wrap_ff, wrap_in;
   logic [EW-1:0] t_ff, t_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_position_ff, rsp_position_in;
   logic [7:0]    rsp_element_ff, rsp_element_in;
   logic          rsp_last_ff, rsp_last_in, rsp_wrapped_ff, rsp_wrapped_in;

   logic [4:0]    len5;
   logic [CW-1:0] n, n_last;
   logic          accept, free, cond, en, emit_fire, idx_ok;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rda, rdb;
   logic [AW+2:0] idx_wide;
   logic [EW+7:0] val_wide, elem_wide;
   logic [CW+2:0] pos_wide;

   assign ctl = lpg_pkg::ucode(upc_ff);

   assign len5   = (length_ff == 4'd0) ? 5'd1 :
                   (({1'b0, length_ff} > MAX5) ? MAX5 : {1'b0, length_ff});
   assign n      = CW'(len5);
   assign n_last = n - CW'(1);

   assign accept    = req_valid && ctl.take;
   assign req_stall = !ctl.take;
   assign free      = !rsp_valid_ff || !rsp_stall;

   assign idx_wide  = {{AW{1'b0}}, req_index};
   assign val_wide  = {{EW{1'b0}}, req_value};
   assign elem_wide = {8'h00, rda};
   assign pos_wide  = {3'b000, p_ff};
   assign idx_ok    = {2'b00, req_index} < MAX5;

   lpg_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (p_in[AW-1:0]),
      .rd_addr_b (q_in[AW-1:0]),
      .rd_data_a (rda),
      .rd_data_b (rdb)
   );

   always_comb begin
      case (ctl.cond)
         lpg_pkg::C_ALWAYS:    cond = 1'b1;
         lpg_pkg::C_DISPATCH:  cond = accept;
         lpg_pkg::C_SCAN:      cond = q_ff < n;
         lpg_pkg::C_FOUND:     cond = found_ff;
         lpg_pkg::C_SUCC:      cond = (q_ff > p_ff) && !(rdb > rda);
         lpg_pkg::C_REV_DONE:  cond = !(p_ff < q_ff);
         lpg_pkg::C_EMIT_DONE: cond = free && (p_ff == n_last);
         default:              cond = 1'b0;
      endcase
      case (ctl.gate)
         lpg_pkg::G_ALWAYS: en = 1'b1;
         lpg_pkg::G_TRUE:   en = cond;
         lpg_pkg::G_FALSE:  en = !cond;
         lpg_pkg::G_FREE:   en = free;
         default:           en = 1'b0;
      endcase
   end

   always_comb begin
      upc_in = cond ? ctl.tgt_t : ctl.tgt_f;
      if (ctl.cond == lpg_pkg::C_DISPATCH) begin
         upc_in = lpg_pkg::U_IDLE;
         if (accept && req_func == lpg_pkg::F_EMIT) begin
            upc_in = lpg_pkg::U_EMIT_SET;
         end else if (accept && req_func == lpg_pkg::F_ADVANCE) begin
            upc_in = lpg_pkg::U_PIV_SET;
         end
      end

      p_in = p_ff;
      if (en) begin
         case (ctl.p_op)
            lpg_pkg::P_HOLD: p_in = p_ff;
            lpg_pkg::P_ZERO: p_in = '0;
            lpg_pkg::P_INC:  p_in = p_ff + CW'(1);
            lpg_pkg::P_PIV:  p_in = piv_ff;
            lpg_pkg::P_PIV1: p_in = piv_ff + CW'(1);
            default:         p_in = p_ff;
         endcase
      end

      q_in = q_ff;
      if (en) begin
         case (ctl.q_op)
            lpg_pkg::Q_HOLD: q_in = q_ff;
            lpg_pkg::Q_ONE:  q_in = CW'(1);
            lpg_pkg::Q_INC:  q_in = q_ff + CW'(1);
            lpg_pkg::Q_DEC:  q_in = q_ff - CW'(1);
            lpg_pkg::Q_LAST: q_in = n_last;
            default:         q_in = q_ff;
         endcase
      end

      wr_en   = 1'b0;
      wr_addr = p_ff[AW-1:0];
      wr_data = rdb;
      case (ctl.wr_sel)
         lpg_pkg::WR_NONE: wr_en = 1'b0;
         lpg_pkg::WR_LOAD: begin
            wr_en   = accept && (req_func == lpg_pkg::F_LOAD) && idx_ok;
            wr_addr = idx_wide[AW-1:0];
            wr_data = val_wide[EW-1:0];
         end
         lpg_pkg::WR_P_RDB: wr_en = en;
         lpg_pkg::WR_Q_T: begin
            wr_en   = en;
            wr_addr = q_ff[AW-1:0];
            wr_data = t_ff;
         end
         default: wr_en = 1'b0;
      endcase

      t_in = (ctl.t_load && en) ? rda : t_ff;

      piv_in   = piv_ff;
      found_in = ctl.found_clr ? 1'b0 : found_ff;
      if (ctl.piv_chk && (q_ff < n) && (rda < rdb)) begin
         piv_in   = p_ff;
         found_in = 1'b1;
      end

      case (ctl.wrap_op)
         lpg_pkg::WRAP_HOLD: wrap_in = wrap_ff;
         lpg_pkg::WRAP_CLR:  wrap_in = 1'b0;
         lpg_pkg::WRAP_SET:  wrap_in = 1'b1;
         default:            wrap_in = wrap_ff;
      endcase

      emit_fire       = ctl.emit && en;
      rsp_valid_in    = emit_fire ? 1'b1 : (rsp_stall && rsp_valid_ff);
      rsp_position_in = emit_fire ? pos_wide[2:0] : rsp_position_ff;
      rsp_element_in  = emit_fire ? elem_wide[7:0] : rsp_element_ff;
      rsp_last_in     = emit_fire ? (p_ff == n_last) : rsp_last_ff;
      rsp_wrapped_in  = emit_fire ? wrap_ff : rsp_wrapped_ff;

      length_in = length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == lpg_pkg::CSR_LENGTH_IDX) begin
         length_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= lpg_pkg::U_IDLE;
         rsp_valid_ff <= 1'b0;
         length_ff    <= lpg_pkg::LENGTH_RESET;
         found_ff     <= 1'b0;
         wrap_ff      <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         length_ff    <= length_in;
         found_ff     <= found_in;
         wrap_ff      <= wrap_in;
      end
      p_ff            <= p_in;
      q_ff            <= q_in;
      piv_ff          <= piv_in;
      t_ff            <= t_in;
      rsp_position_ff <= rsp_position_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_wrapped_ff  <= rsp_wrapped_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_wrapped  = rsp_wrapped_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == lpg_pkg::CSR_LENGTH_IDX) ?
                       {28'd0, length_ff} : 32'd0;

`ifndef SYNTHESIS
   a_succ_bound: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == lpg_pkg::U_SUCC) |-> (q_ff >= p_ff))
      else $error("successor walk passed the pivot");

   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == lpg_pkg::U_REV_B) |-> (p_ff < q_ff))
      else $error("reversal swap with crossed pointers");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(upc_ff) == lpg_pkg::U_EMIT))
      else $error("result word raised outside the emit step");

   a_rsp_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a run of result words");
`endif

endmodule

/* test/lpg_arrangement_checker.sv */
`timescale 1ns / 100ps
// Checker for the lexicographic permutation generator: watches the request, result
// and register ports, keeps a shadow arrangement and compares every result word.
// Depends on lpg_pkg.
module lpg_arrangement_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_index,
   input  logic [7:0]  req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_position,
   input  logic [7:0]  rsp_element,
   input  logic        rsp_last,
   input  logic        rsp_wrapped,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [2:0] position;
      logic [7:0] element;
      logic       last;
      logic       wrapped;
   } rsp_word_type;

   localparam logic [2:0] LENGTH_ADDR = {lpg_pkg::CSR_LENGTH_IDX, 2'b00};

   logic [7:0]   shadow_elements [0:7];
   logic [3:0]   length_now;
   rsp_word_type expected_words [$];

   function automatic int active_count();
      if (length_now == 4'd0) return 1;
      if (length_now > 4'd8) return 8;
      return int'(length_now);
   endfunction

   function automatic void swap_elements(input int a, input int b);
      logic [7:0] t;
      t = shadow_elements[a];
      shadow_elements[a] = shadow_elements[b];
      shadow_elements[b] = t;
   endfunction

   function automatic void reverse_run(input int lo, input int hi);
      int a;
      int b;
      a = lo;
      b = hi;
      while (a < b) begin
         swap_elements(a, b);
         a++;
         b--;
      end
   endfunction

   // Step to the next arrangement; return 1 when it wrapped to ascending order.
   function automatic logic next_arrangement(input int n);
      int   piv;
      int   j;
      logic found;
      found = 1'b0;
      piv = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (shadow_elements[i] < shadow_elements[i + 1]) begin
            piv = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         reverse_run(0, n - 1);
         return 1'b1;
      end
      j = n - 1;
      while (j > piv && !(shadow_elements[j] > shadow_elements[piv])) j--;
      swap_elements(piv, j);
      reverse_run(piv + 1, n - 1);
      return 1'b0;
   endfunction

   function automatic void queue_arrangement(input int n, input logic wrap);
      rsp_word_type w;
      for (int k = 0; k < n; k++) begin
         w.position = 3'(k);
         w.element  = shadow_elements[k];
         w.last     = (k == n - 1);
         w.wrapped  = wrap;
         expected_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      logic         wrap;
      if (reset) begin
         expected_words.delete();
         length_now = lpg_pkg::LENGTH_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word position %0d element %0d last %0b wrapped %0b",
                        $time, rsp_position, rsp_element, rsp_last, rsp_wrapped);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_position !== want.position) begin
                  $display("%0t: position expected %0d got %0d",
                           $time, want.position, rsp_position);
                  errors++;
               end
               if (rsp_element !== want.element) begin
                  $display("%0t: element expected %0d got %0d",
                           $time, want.element, rsp_element);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
                  errors++;
               end
               if (rsp_wrapped !== want.wrapped) begin
                  $display("%0t: wrapped expected %0b got %0b",
                           $time, want.wrapped, rsp_wrapped);
                  errors++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LENGTH_ADDR)
            length_now = csr_pwdata[3:0];
         if (req_valid && !req_stall) begin
            case (req_func)
               lpg_pkg::F_LOAD: shadow_elements[req_index] = req_value;
               lpg_pkg::F_EMIT: queue_arrangement(active_count(), 1'b0);
               lpg_pkg::F_ADVANCE: begin
                  wrap = next_arrangement(active_count());
                  queue_arrangement(active_count(), wrap);
               end
               default: ;
            endcase
         end
      end
      pending = expected_words.size();
   end

endmodule

/* test/lexicographic_permutation_generator_test.sv */
`timescale 1ns / 100ps
// Testbench top for the lexicographic permutation generator: drives loads, emits and
// advances under random gaps and stalls, and reports the verdict.
// Depends on lpg_pkg, lpg_arrangement_checker and the block itself.
module lexicographic_permutation_generator_test;

   localparam logic [1:0] F_UNUSED      = 2'd3;
   localparam logic [2:0] LENGTH_ADDR   = {lpg_pkg::CSR_LENGTH_IDX, 2'b00};
   localparam int         ITEMS         = 280;
   localparam int         SETTLE_CYCLES = 60;
   localparam int         QUIET_LIMIT   = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [2:0]  req_index;
   logic [7:0]  req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_position;
   logic [7:0]  rsp_element;
   logic        rsp_last;
   logic        rsp_wrapped;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          burst_left = 0;
   int          words_sent = 0;
   int          quiet_cycles = 0;

   lexicographic_permutation_generator i_dut (.*);

   lpg_arrangement_checker i_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic put_word(input logic [1:0] f, input logic [2:0] ix, input logic [7:0] v);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func  <= f;
      req_index <= ix;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      if (f != F_UNUSED) words_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [3:0] len);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= LENGTH_ADDR;
      csr_pwdata  <= {28'($urandom), len};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= (k % 4 == 3);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int len;
      int count;
      int r;
      int cur;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = lpg_pkg::F_LOAD;
      req_index   = 3'd0;
      req_value   = 8'd0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = LENGTH_ADDR;
      csr_pwdata  = 32'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      put_word(lpg_pkg::F_LOAD, 3'd0, 8'h00);
      put_word(lpg_pkg::F_LOAD, 3'd1, 8'hFF);
      put_word(lpg_pkg::F_LOAD, 3'd2, 8'h55);
      put_word(lpg_pkg::F_LOAD, 3'd3, 8'hAA);
      put_word(lpg_pkg::F_LOAD, 3'd4, 8'h01);
      put_word(lpg_pkg::F_LOAD, 3'd5, 8'h80);
      put_word(lpg_pkg::F_LOAD, 3'd6, 8'h7F);
      put_word(lpg_pkg::F_LOAD, 3'd7, 8'h2C);
      put_word(lpg_pkg::F_EMIT, 3'($urandom), 8'($urandom));
      put_word(lpg_pkg::F_ADVANCE, 3'($urandom), 8'($urandom));
      put_word(F_UNUSED, 3'($urandom), 8'($urandom));
      settle();
      write_length(4'd3);
      put_word(lpg_pkg::F_LOAD, 3'd0, 8'd30);
      put_word(lpg_pkg::F_LOAD, 3'd1, 8'd20);
      put_word(lpg_pkg::F_LOAD, 3'd2, 8'd10);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);
      put_word(lpg_pkg::F_LOAD, 3'd2, 8'd10);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);
      put_word(lpg_pkg::F_EMIT, 3'd0, 8'd0);
      settle();
      write_length(4'd1);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);
      put_word(lpg_pkg::F_EMIT, 3'd0, 8'd0);
      settle();
      write_length(4'd0);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);
      settle();
      write_length(4'd15);
      put_word(lpg_pkg::F_EMIT, 3'd0, 8'd0);
      put_word(lpg_pkg::F_ADVANCE, 3'd0, 8'd0);

      while (words_sent < ITEMS) begin
         settle();
         r = $urandom_range(0, 9);
         if (r < 5) len = $urandom_range(2, 4);
         else if (r == 5) len = 0;
         else if (r == 6) len = 15;
         else len = $urandom_range(1, 15);
         write_length(4'(len));
         count = $urandom_range(10, 40);
         repeat (count) begin
            if (words_sent >= ITEMS) break;
            r = $urandom_range(0, 99);
            if (r < 45) begin
               put_word(lpg_pkg::F_ADVANCE, 3'($urandom), 8'($urandom));
            end else if (r < 57) begin
               put_word(lpg_pkg::F_EMIT, 3'($urandom), 8'($urandom));
            end else if (r < 67) begin
               put_word(lpg_pkg::F_LOAD, 3'($urandom), 8'($urandom_range(0, 3)));
            end else if (r < 77) begin
               put_word(lpg_pkg::F_LOAD, 3'($urandom), 8'($urandom));
            end else if (r < 82) begin
               put_word(F_UNUSED, 3'($urandom), 8'($urandom));
            end else begin
               cur = $urandom_range(180, 255);
               for (int k = 0; k < 8; k++) begin
                  put_word(lpg_pkg::F_LOAD, 3'(k), 8'(cur));
                  cur = (cur > 30) ? cur - int'($urandom_range(0, 30)) : 0;
               end
               put_word(lpg_pkg::F_ADVANCE, 3'($urandom), 8'($urandom));
            end
         end
      end

      settle();
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* lexicographic_permutation_generator.f */
src/lpg_pkg.sv
src/lpg_ram.sv
src/lexicographic_permutation_generator.sv
test/lpg_arrangement_checker.sv
test/lexicographic_permutation_generator_test.sv
